FILE: rtl/core/priority_ready_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef PRIORITY_READY_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/prs_pkg.sv
// Package for the priority ready scheduler: sizes, op codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package prs_pkg;

    localparam int CORES  = 4;
    localparam int PROCS  = 64;
    localparam int QW     = $clog2(PROCS);
    localparam int CW     = $clog2(PROCS + 1);
    localparam int CIW    = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int PIDW   = 6;
    localparam int PRIOW  = 15;
    localparam int DEPTHW = 8;
    localparam int SLICEW = 8;
    localparam int OPW    = 2;

    localparam logic [OPW-1:0] OP_MAKE_READY  = 2'd0;
    localparam logic [OPW-1:0] OP_RESCHED     = 2'd1;
    localparam logic [OPW-1:0] OP_DEFER_START = 2'd2;
    localparam logic [OPW-1:0] OP_DEFER_STOP  = 2'd3;

    typedef struct packed {
        logic [PIDW-1:0]  pid;
        logic [PRIOW-1:0] prio;
    } t_q_ent;

    typedef struct packed {
        logic   ins;
        logic   pop;
        t_q_ent ent;
    } t_q_cmd;

    typedef struct packed {
        logic [CW-1:0] count;
        logic          done;
        t_q_ent        head;
    } t_q_stat;

    typedef struct packed {
        logic [PIDW-1:0]   pid;
        logic [PRIOW-1:0]  prio;
        logic [DEPTHW-1:0] depth;
        logic              pend;
    } t_core_ent;

    typedef struct packed {
        logic           rd_en;
        logic [CIW-1:0] rd_idx;
        logic           wr_en;
        logic [CIW-1:0] wr_idx;
        t_core_ent      wr_ent;
    } t_ct_req;

    typedef struct packed {
        logic              status;
        logic              switched;
        logic              deferred;
        logic [PIDW-1:0]   old_pid;
        logic [PIDW-1:0]   new_pid;
        logic [SLICEW-1:0] slice;
    } t_res;

endpackage

FILE: rtl/core/prs_core_tbl.sv
// Per-core state table: current process, priority, deferral depth, pending flag.
// Depends on prs_pkg. Synchronous memory, registered read, valid bit per core.
`timescale 1ns / 1ps

module prs_core_tbl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prs_pkg::t_ct_req   i_req,
    output prs_pkg::t_core_ent o_rd_ent
);
    import prs_pkg::*;

    t_core_ent        r_mem [CORES];
    logic [CORES-1:0] r_vld;
    t_core_ent        r_q;
    logic             r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_ent;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_idx] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_q_vld <= r_vld[i_req.rd_idx];
            end
        end
    end

    assign o_rd_ent = r_q_vld ? r_q : '0;

endmodule

FILE: rtl/core/prs_queue.sv
// Sorted ready queue in a circular synchronous memory with registered read.
// Depends on prs_pkg. Pop advances the head; insert shifts the tail one entry a cycle.
`timescale 1ns / 1ps
`include "priority_ready_scheduler_defines.svh"

module prs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prs_pkg::t_q_cmd  i_cmd,
    output prs_pkg::t_q_stat o_stat
);
    import prs_pkg::*;

    localparam logic [1:0] Q_IDLE = 2'd0;
    localparam logic [1:0] Q_CMP  = 2'd1;
    localparam logic [1:0] Q_PUT  = 2'd2;

    t_q_ent        r_mem [PROCS];
    t_q_ent        r_rd;
    t_q_ent        r_new;
    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [QW-1:0] r_head;
    logic [QW-1:0] n_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [QW-1:0] r_idx;
    logic [QW-1:0] n_idx;
    logic [QW-1:0] rd_addr;
    logic          wr_en;
    logic [QW-1:0] wr_addr;
    t_q_ent        wr_data;
    logic          done;

    function automatic logic [QW-1:0] phys(input logic [QW-1:0] base,
                                           input logic [QW-1:0] off);
        logic [QW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (QW+1)'(PROCS)) begin
            sum = sum - (QW+1)'(PROCS);
        end
        return sum[QW-1:0];
    endfunction

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_idx   = r_idx;
        rd_addr = r_head;
        wr_en   = 1'b0;
        wr_addr = phys(r_head, r_idx);
        wr_data = r_new;
        done    = 1'b0;
        case (r_state)
            Q_IDLE: begin
                if (i_cmd.pop) begin
                    n_head  = phys(r_head, QW'(1));
                    n_count = r_count - 1'b1;
                end else if (i_cmd.ins) begin
                    n_idx = QW'(r_count);
                    if (r_count == '0) begin
                        n_state = Q_PUT;
                    end else begin
                        rd_addr = phys(r_head, QW'(r_count - 1'b1));
                        n_state = Q_CMP;
                    end
                end
            end
            Q_CMP: begin
                if (r_rd.prio < r_new.prio) begin
                    wr_en   = 1'b1;
                    wr_data = r_rd;
                    n_idx   = r_idx - 1'b1;
                    if (r_idx == QW'(1)) begin
                        n_state = Q_PUT;
                    end else begin
                        rd_addr = phys(r_head, r_idx - QW'(2));
                    end
                end else begin
                    wr_en   = 1'b1;
                    done    = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = Q_IDLE;
                end
            end
            Q_PUT: begin
                wr_en   = 1'b1;
                done    = 1'b1;
                n_count = r_count + 1'b1;
                n_state = Q_IDLE;
            end
            default: begin
                n_state = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
        if (r_state == Q_IDLE && i_cmd.ins) begin
            r_new <= i_cmd.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    assign o_stat.count = r_count;
    assign o_stat.done  = done;
    assign o_stat.head  = r_rd;

    `PRS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(PROCS), "queue count above capacity")
    `PRS_ASSERT_NOW(a_ins_ok, i_cmd.ins, (r_state == Q_IDLE) && (r_count < CW'(PROCS)), "insert while busy or full")
    `PRS_ASSERT_NOW(a_pop_ok, i_cmd.pop, (r_state == Q_IDLE) && (r_count != '0) && !i_cmd.ins, "pop while busy or empty")
    `PRS_ASSERT_NEXT(a_done_count, done, r_count == $past(r_count) + 1'b1, "insert did not grow the queue")

endmodule

FILE: rtl/core/priority_ready_scheduler.sv
// Top level of the priority ready scheduler: item decode, decision and result register.
// Depends on prs_pkg, prs_queue and prs_core_tbl.
`timescale 1ns / 1ps
`include "priority_ready_scheduler_defines.svh"

// Usage:
//   Input: drive i_op, i_core, i_pid, i_prio, i_cur_eligible with start; the item is
//   taken at a rising edge where start is high and busy is low.
//   Result: o_res_valid is high for one cycle with all result fields; it cannot be
//   held off, so sample it in that cycle.
//   Config: i_cfg_data written with i_cfg_valid; o_cfg_ready is always high. Write
//   only while busy is low and no result is outstanding.
//   Sequence: result valid in the cycle after the item settles. Make ready on a
//   full queue and an out-of-range core settle at once (busy stays low).
//   Reschedule without a switch, defer start and defer stop read the per-core
//   table, then decide. Make ready runs the queue insert, which shifts each queue
//   entry of lower priority one place toward the tail; a switch that requeues the
//   current process adds a request state and a queue insert with those shifts.
//   Reset: queue empty, every core runs process 0 at priority 0 with no deferral,
//   time slice 2. No clearing pass is needed.
module priority_ready_scheduler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [prs_pkg::OPW-1:0]      i_op,
    input  logic [1:0]                   i_core,
    input  logic [prs_pkg::PIDW-1:0]     i_pid,
    input  logic [prs_pkg::PRIOW-1:0]    i_prio,
    input  logic                         i_cur_eligible,
    output logic                         o_res_valid,
    output logic                         o_status,
    output logic                         o_switched,
    output logic                         o_deferred,
    output logic [prs_pkg::PIDW-1:0]     o_old_pid,
    output logic [prs_pkg::PIDW-1:0]     o_new_pid,
    output logic [prs_pkg::SLICEW-1:0]   o_slice,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [prs_pkg::SLICEW-1:0]   i_cfg_data
);
    import prs_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_REQ    = 2'd2;
    localparam logic [1:0] S_WAIT   = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [OPW-1:0]    r_op;
    logic [CIW-1:0]    r_core;
    logic              r_elig;
    t_q_ent            r_req;
    t_q_ent            n_req;
    t_res              r_res;
    t_res              n_res;
    logic              r_res_vld;
    logic              n_res_vld;
    logic [SLICEW-1:0] r_time_slice;

    t_q_cmd    q_cmd;
    t_q_stat   q_stat;
    t_ct_req   ct_req;
    t_core_ent cur;

    t_core_ent dec_ent;
    t_res      dec_res;
    logic      dec_wr;
    logic      dec_pop;
    logic      dec_req;
    logic      resched;
    logic      core_bad;

    prs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    prs_core_tbl u_core_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (ct_req),
        .o_rd_ent (cur)
    );

    assign core_bad = (int'(i_core) >= CORES);

    always_comb begin
        dec_ent          = cur;
        dec_res          = '0;
        dec_res.old_pid  = cur.pid;
        dec_res.new_pid  = cur.pid;
        dec_wr           = 1'b0;
        dec_pop          = 1'b0;
        dec_req          = 1'b0;
        resched          = 1'b0;
        case (r_op)
            OP_RESCHED: begin
                if (cur.depth != '0) begin
                    dec_ent.pend     = 1'b1;
                    dec_wr           = 1'b1;
                    dec_res.deferred = 1'b1;
                end else begin
                    resched = 1'b1;
                end
            end
            OP_DEFER_START: begin
                if (cur.depth == '0) begin
                    dec_ent.pend = 1'b0;
                end
                if (cur.depth != '1) begin
                    dec_ent.depth = cur.depth + 1'b1;
                end
                dec_wr = 1'b1;
            end
            OP_DEFER_STOP: begin
                if (cur.depth == '0) begin
                    dec_res.status = 1'b1;
                end else begin
                    dec_ent.depth = cur.depth - 1'b1;
                    dec_wr        = 1'b1;
                    if (cur.depth == DEPTHW'(1) && cur.pend) begin
                        resched = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (resched) begin
            if (r_elig && (q_stat.count == '0 || cur.prio > q_stat.head.prio)) begin
                dec_wr = dec_wr;
            end else if (!r_elig && q_stat.count == '0) begin
                dec_res.status = 1'b1;
            end else begin
                dec_pop          = 1'b1;
                dec_req          = r_elig;
                dec_wr           = 1'b1;
                dec_ent.pid      = q_stat.head.pid;
                dec_ent.prio     = q_stat.head.prio;
                dec_res.switched = 1'b1;
                dec_res.new_pid  = q_stat.head.pid;
                dec_res.slice    = r_time_slice;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_res     = r_res;
        n_res_vld = 1'b0;
        q_cmd     = '0;
        ct_req    = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res = '0;
                    if (i_op == OP_MAKE_READY) begin
                        if (q_stat.count == CW'(PROCS)) begin
                            n_res.status = 1'b1;
                            n_res_vld    = 1'b1;
                        end else begin
                            q_cmd.ins      = 1'b1;
                            q_cmd.ent.pid  = i_pid;
                            q_cmd.ent.prio = i_prio;
                            n_state        = S_WAIT;
                        end
                    end else if (core_bad) begin
                        n_res.status = 1'b1;
                        n_res_vld    = 1'b1;
                    end else begin
                        ct_req.rd_en  = 1'b1;
                        ct_req.rd_idx = CIW'(i_core);
                        n_state       = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                ct_req.wr_en  = dec_wr;
                ct_req.wr_idx = r_core;
                ct_req.wr_ent = dec_ent;
                q_cmd.pop     = dec_pop;
                n_res         = dec_res;
                n_req.pid     = cur.pid;
                n_req.prio    = cur.prio;
                if (dec_req) begin
                    n_state = S_REQ;
                end else begin
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_REQ: begin
                q_cmd.ins = 1'b1;
                q_cmd.ent = r_req;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                if (q_stat.done) begin
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        if (r_state == S_IDLE && start) begin
            r_op   <= i_op;
            r_core <= CIW'(i_core);
            r_elig <= i_cur_eligible;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_vld    <= 1'b0;
            r_time_slice <= SLICEW'(2);
        end else begin
            r_state   <= n_state;
            r_res_vld <= n_res_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_time_slice <= i_cfg_data;
            end
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_vld;
    assign o_status    = r_res.status;
    assign o_switched  = r_res.switched;
    assign o_deferred  = r_res.deferred;
    assign o_old_pid   = r_res.old_pid;
    assign o_new_pid   = r_res.new_pid;
    assign o_slice     = r_res.slice;

    `PRS_ASSERT_NOW(a_decide_from_idle, r_state == S_DECIDE, $past(r_state) == S_IDLE,
                    "decide not entered from idle")
    `PRS_ASSERT_NOW(a_switch_clean, o_res_valid && o_switched, !o_status && !o_deferred,
                    "switch reported with error or deferral")
    `PRS_ASSERT_NOW(a_done_in_wait, q_stat.done, r_state == S_WAIT,
                    "queue insert finished outside wait")

endmodule
